// ===== hdl/tqdc_pkg.sv =====
// Shared constants, types and helper functions of the Q-learning duty controller.
`timescale 1ns / 1ps

package tqdc_pkg;

  // Field and table widths.
  localparam int Q_WIDTH        = 48;
  localparam int FRAC_BITS      = 8;
  localparam int BYTES_W        = 32;
  localparam int CFG_W          = 17;
  localparam int THR_W          = 10;
  localparam int STATE_W        = 2;
  localparam int ACT_W          = 2;
  localparam int BLANK_W        = 4;
  localparam int COST_W         = 32;
  localparam int CFG_IDX_W      = 3;

  // Fixed-point constants.
  localparam int BYTES_PER_MBPS = 5000;
  localparam int ONE_Q16        = 65536;

  // Constant divider: numerator bytes * 2^FRAC_BITS, several quotient bits per cycle.
  localparam int DIV_DIGIT      = 4;
  localparam int NUM_W          = BYTES_W + FRAC_BITS;
  localparam int DIV_STEPS      = (NUM_W + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int DIV_PAD_W      = DIV_STEPS * DIV_DIGIT;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int REM_W          = $clog2(BYTES_PER_MBPS);
  localparam int TPUT_W         = NUM_W - REM_W + 1;
  localparam int SUM_W          = TPUT_W + 1;
  localparam int COST_EXT_W     = (SUM_W > COST_W) ? SUM_W : COST_W + 1;

  // Q table geometry.
  localparam int N_ENTRIES      = 9;
  localparam int ADDR_W         = $clog2(N_ENTRIES);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd4;

  // Throughput state codes.
  localparam logic [STATE_W-1:0] TS_LOW  = 2'd0;
  localparam logic [STATE_W-1:0] TS_MID  = 2'd1;
  localparam logic [STATE_W-1:0] TS_HIGH = 2'd2;

  // Action codes and their blank fractions in tenths.
  localparam logic [ACT_W-1:0]   ACT_SHORT   = 2'd0;
  localparam logic [ACT_W-1:0]   ACT_MID     = 2'd1;
  localparam logic [ACT_W-1:0]   ACT_LONG    = 2'd2;
  localparam logic [BLANK_W-1:0] BLANK_SHORT = 4'd3;
  localparam logic [BLANK_W-1:0] BLANK_MID   = 4'd6;
  localparam logic [BLANK_W-1:0] BLANK_LONG  = 4'd9;

  // Configuration register file contents.
  typedef struct packed {
    logic [CFG_W-1:0] learn_rate;
    logic [CFG_W-1:0] discount;
    logic [THR_W-1:0] low_thr;
    logic [THR_W-1:0] high_thr;
    logic [THR_W-1:0] target;
  } cfg_t;

  // Request from the sequencer to the Q table memory.
  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [Q_WIDTH-1:0] wr_data;
  } qmem_req_t;

  // One result request.
  typedef struct packed {
    logic [STATE_W-1:0] state_index;
    logic [ACT_W-1:0]   action_index;
    logic [BLANK_W-1:0] blank_tenths;
    logic [COST_W-1:0]  cost_q8;
  } result_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DIV,
    CS_CLASS,
    CS_RD0,
    CS_RD1,
    CS_RD2,
    CS_RDOLD,
    CS_MIN,
    CS_GMUL,
    CS_TSUM,
    CS_UMUL,
    CS_WRITE,
    CS_DONE
  } ctrl_state_e;

  // Table address of a (state, action) pair: state * 3 + action.
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [STATE_W-1:0] s,
                                                   input logic [ACT_W-1:0] a);
    entry_addr = ADDR_W'(s) + ADDR_W'(s) + ADDR_W'(s) + ADDR_W'(a);
  endfunction

  // Blank fraction for an action.
  function automatic logic [BLANK_W-1:0] blank_of(input logic [ACT_W-1:0] a);
    case (a)
      ACT_SHORT: blank_of = BLANK_SHORT;
      ACT_MID:   blank_of = BLANK_MID;
      ACT_LONG:  blank_of = BLANK_LONG;
      default:   blank_of = BLANK_SHORT;
    endcase
  endfunction

endpackage

// ===== hdl/tqdc_div.sv =====
// Iterative divider of a byte count scaled by 2^FRAC_BITS by the constant bytes per Mbps.
`timescale 1ns / 1ps

module tqdc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tqdc_pkg::BYTES_W-1:0]      bytes_i,
  output logic                              done_o,
  output logic [tqdc_pkg::TPUT_W-1:0]       quot_o
);

  logic                                busy_q, busy_d;
  logic [tqdc_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [tqdc_pkg::DIV_PAD_W-1:0]      num_q, num_d;
  logic [tqdc_pkg::DIV_PAD_W-1:0]      quo_q, quo_d;
  logic [tqdc_pkg::REM_W-1:0]          rem_q, rem_d;
  logic [tqdc_pkg::REM_W-1:0]          rem_step;
  logic [tqdc_pkg::DIV_DIGIT-1:0]      digit;

  // Restoring division, DIV_DIGIT quotient bits per cycle.
  always_comb begin
    logic [tqdc_pkg::REM_W:0]   trial;
    logic [tqdc_pkg::REM_W-1:0] r;
    r     = rem_q;
    digit = '0;
    for (int i = 0; i < tqdc_pkg::DIV_DIGIT; i++) begin
      trial = {r, num_q[tqdc_pkg::DIV_PAD_W-1-i]};
      if (trial >= (tqdc_pkg::REM_W+1)'(tqdc_pkg::BYTES_PER_MBPS)) begin
        trial = trial - (tqdc_pkg::REM_W+1)'(tqdc_pkg::BYTES_PER_MBPS);
        digit[tqdc_pkg::DIV_DIGIT-1-i] = 1'b1;
      end
      r = trial[tqdc_pkg::REM_W-1:0];
    end
    rem_step = r;
  end

  // Load on start, step while busy.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tqdc_pkg::DIV_CNT_W'(tqdc_pkg::DIV_STEPS - 1);
      num_d  = tqdc_pkg::DIV_PAD_W'({bytes_i, {tqdc_pkg::FRAC_BITS{1'b0}}});
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = num_q << tqdc_pkg::DIV_DIGIT;
      quo_d = {quo_q[tqdc_pkg::DIV_PAD_W-tqdc_pkg::DIV_DIGIT-1:0], digit};
      rem_d = rem_step;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quo_q[tqdc_pkg::TPUT_W-1:0];

endmodule

// ===== hdl/tqdc_qmem.sv =====
// Q table: synchronous memory with one read and one write port and per-entry valid bits.
`timescale 1ns / 1ps

module tqdc_qmem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tqdc_pkg::qmem_req_t           req_i,
  output logic [tqdc_pkg::Q_WIDTH-1:0]  rd_data_o
);

  logic [tqdc_pkg::Q_WIDTH-1:0]   mem_q [tqdc_pkg::N_ENTRIES];
  logic [tqdc_pkg::N_ENTRIES-1:0] valid_q;
  logic [tqdc_pkg::Q_WIDTH-1:0]   rd_data_q;
  logic                           rd_valid_q;

  // Storage and registered read data.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // Entries not yet written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hdl/tqdc_ctrl.sv =====
// Sequencer and datapath: state classification, cost and the Q table update.
`timescale 1ns / 1ps

module tqdc_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tqdc_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tqdc_pkg::BYTES_W-1:0]      lte_bytes_i,
  output logic                              div_start_o,
  input  logic                              div_done_i,
  input  logic [tqdc_pkg::TPUT_W-1:0]       lte_tput_i,
  input  logic [tqdc_pkg::TPUT_W-1:0]       wifi_tput_i,
  output tqdc_pkg::qmem_req_t               mem_req_o,
  input  logic [tqdc_pkg::Q_WIDTH-1:0]      mem_rd_data_i,
  input  logic                              out_free_i,
  output logic                              res_valid_o,
  output tqdc_pkg::result_t                 res_o
);

  localparam int PROD_W = tqdc_pkg::Q_WIDTH + tqdc_pkg::CFG_W;

  tqdc_pkg::ctrl_state_e state_q, state_d;

  logic [tqdc_pkg::STATE_W-1:0] pres_state_q, pres_state_d;
  logic [tqdc_pkg::ACT_W-1:0]   pres_action_q, pres_action_d;

  logic [tqdc_pkg::STATE_W-1:0] new_state_q, new_state_d;
  logic [tqdc_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [tqdc_pkg::COST_W-1:0]  cost_q, cost_d;
  logic [tqdc_pkg::Q_WIDTH-1:0] row_q [3];
  logic [tqdc_pkg::Q_WIDTH-1:0] old_q, minq_q, minq_d, g_q, g_d, t_q, t_d;
  logic [tqdc_pkg::Q_WIDTH-1:0] p1_q, p1_d, p2_q, p2_d, newq_d;
  logic [tqdc_pkg::ACT_W-1:0]   act_d;

  logic [tqdc_pkg::CFG_W-1:0]   alpha, gamma, one_minus_alpha;
  logic [PROD_W-1:0]            g_prod, p1_prod, p2_prod;
  logic [tqdc_pkg::Q_WIDTH:0]   t_sum, q_sum;
  logic [tqdc_pkg::TPUT_W-1:0]  low_ext, high_ext;
  logic [tqdc_pkg::SUM_W-1:0]   target_ext, diff;
  logic [tqdc_pkg::COST_EXT_W-1:0] diff_ext;
  logic [tqdc_pkg::ADDR_W-1:0]  old_addr;

  // First minimum of three entries.
  function automatic logic [tqdc_pkg::ACT_W-1:0] row_argmin(
    input logic [tqdc_pkg::Q_WIDTH-1:0] r0,
    input logic [tqdc_pkg::Q_WIDTH-1:0] r1,
    input logic [tqdc_pkg::Q_WIDTH-1:0] r2
  );
    logic [tqdc_pkg::Q_WIDTH-1:0] best;
    row_argmin = tqdc_pkg::ACT_SHORT;
    best       = r0;
    if (r1 < best) begin
      row_argmin = tqdc_pkg::ACT_MID;
      best       = r1;
    end
    if (r2 < best) begin
      row_argmin = tqdc_pkg::ACT_LONG;
    end
  endfunction

  // Fractions above one act as one.
  assign alpha = (cfg_i.learn_rate > tqdc_pkg::CFG_W'(tqdc_pkg::ONE_Q16)) ?
                 tqdc_pkg::CFG_W'(tqdc_pkg::ONE_Q16) : cfg_i.learn_rate;
  assign gamma = (cfg_i.discount > tqdc_pkg::CFG_W'(tqdc_pkg::ONE_Q16)) ?
                 tqdc_pkg::CFG_W'(tqdc_pkg::ONE_Q16) : cfg_i.discount;
  assign one_minus_alpha = tqdc_pkg::CFG_W'(tqdc_pkg::ONE_Q16) - alpha;

  // State classification and combined throughput.
  assign low_ext  = tqdc_pkg::TPUT_W'({cfg_i.low_thr, {tqdc_pkg::FRAC_BITS{1'b0}}});
  assign high_ext = tqdc_pkg::TPUT_W'({cfg_i.high_thr, {tqdc_pkg::FRAC_BITS{1'b0}}});
  always_comb begin
    if (lte_tput_i <= low_ext) begin
      new_state_d = tqdc_pkg::TS_LOW;
    end else if (lte_tput_i <= high_ext) begin
      new_state_d = tqdc_pkg::TS_MID;
    end else begin
      new_state_d = tqdc_pkg::TS_HIGH;
    end
  end
  assign sum_d = tqdc_pkg::SUM_W'(lte_tput_i) + tqdc_pkg::SUM_W'(wifi_tput_i);

  // Cost: distance from target, saturated to the output width.
  assign target_ext = tqdc_pkg::SUM_W'({cfg_i.target, {tqdc_pkg::FRAC_BITS{1'b0}}});
  assign diff       = (target_ext >= sum_q) ? target_ext - sum_q : sum_q - target_ext;
  assign diff_ext   = tqdc_pkg::COST_EXT_W'(diff);
  assign cost_d     = (diff_ext[tqdc_pkg::COST_EXT_W-1:tqdc_pkg::COST_W] != '0) ?
                      '1 : diff_ext[tqdc_pkg::COST_W-1:0];

  // Row minimum before the update.
  always_comb begin
    case (row_argmin(row_q[0], row_q[1], row_q[2]))
      tqdc_pkg::ACT_MID:  minq_d = row_q[1];
      tqdc_pkg::ACT_LONG: minq_d = row_q[2];
      default:            minq_d = row_q[0];
    endcase
  end

  // Discounted minimum, saturated target value, blended entry.
  assign g_prod  = minq_q * gamma;
  assign g_d     = g_prod[tqdc_pkg::Q_WIDTH+15:16];
  assign t_sum   = (tqdc_pkg::Q_WIDTH+1)'(g_q) + (tqdc_pkg::Q_WIDTH+1)'(cost_q);
  assign t_d     = t_sum[tqdc_pkg::Q_WIDTH] ? '1 : t_sum[tqdc_pkg::Q_WIDTH-1:0];
  assign p1_prod = old_q * one_minus_alpha;
  assign p2_prod = t_q * alpha;
  assign p1_d    = p1_prod[tqdc_pkg::Q_WIDTH+15:16];
  assign p2_d    = p2_prod[tqdc_pkg::Q_WIDTH+15:16];
  assign q_sum   = (tqdc_pkg::Q_WIDTH+1)'(p1_q) + (tqdc_pkg::Q_WIDTH+1)'(p2_q);
  assign newq_d  = q_sum[tqdc_pkg::Q_WIDTH-1:0];

  // Action from the updated row.
  assign act_d    = row_argmin(row_q[0], row_q[1], row_q[2]);
  assign old_addr = tqdc_pkg::entry_addr(pres_state_q, pres_action_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tqdc_pkg::CS_IDLE: begin
        if (in_valid_i && (lte_bytes_i != '0)) begin
          state_d = tqdc_pkg::CS_DIV;
        end
      end
      tqdc_pkg::CS_DIV: begin
        if (div_done_i) begin
          state_d = tqdc_pkg::CS_CLASS;
        end
      end
      tqdc_pkg::CS_CLASS: state_d = tqdc_pkg::CS_RD0;
      tqdc_pkg::CS_RD0:   state_d = tqdc_pkg::CS_RD1;
      tqdc_pkg::CS_RD1:   state_d = tqdc_pkg::CS_RD2;
      tqdc_pkg::CS_RD2:   state_d = tqdc_pkg::CS_RDOLD;
      tqdc_pkg::CS_RDOLD: state_d = tqdc_pkg::CS_MIN;
      tqdc_pkg::CS_MIN:   state_d = tqdc_pkg::CS_GMUL;
      tqdc_pkg::CS_GMUL:  state_d = tqdc_pkg::CS_TSUM;
      tqdc_pkg::CS_TSUM:  state_d = tqdc_pkg::CS_UMUL;
      tqdc_pkg::CS_UMUL:  state_d = tqdc_pkg::CS_WRITE;
      tqdc_pkg::CS_WRITE: state_d = tqdc_pkg::CS_DONE;
      tqdc_pkg::CS_DONE: begin
        if (out_free_i) begin
          state_d = tqdc_pkg::CS_IDLE;
        end
      end
      default: state_d = tqdc_pkg::CS_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o        = 1'b0;
    div_start_o       = 1'b0;
    res_valid_o       = 1'b0;
    mem_req_o         = '0;
    mem_req_o.wr_data = newq_d;
    pres_state_d      = pres_state_q;
    pres_action_d     = pres_action_q;
    case (state_q)
      tqdc_pkg::CS_IDLE: begin
        in_ready_o  = 1'b1;
        div_start_o = in_valid_i && (lte_bytes_i != '0);
      end
      tqdc_pkg::CS_RD0: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = tqdc_pkg::entry_addr(new_state_q, tqdc_pkg::ACT_SHORT);
      end
      tqdc_pkg::CS_RD1: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = tqdc_pkg::entry_addr(new_state_q, tqdc_pkg::ACT_MID);
      end
      tqdc_pkg::CS_RD2: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = tqdc_pkg::entry_addr(new_state_q, tqdc_pkg::ACT_LONG);
      end
      tqdc_pkg::CS_RDOLD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = old_addr;
      end
      tqdc_pkg::CS_WRITE: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = old_addr;
      end
      tqdc_pkg::CS_DONE: begin
        res_valid_o = 1'b1;
        if (out_free_i) begin
          pres_state_d  = new_state_q;
          pres_action_d = act_d;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tqdc_pkg::CS_IDLE;
      pres_state_q  <= tqdc_pkg::TS_LOW;
      pres_action_q <= tqdc_pkg::ACT_SHORT;
    end else begin
      state_q       <= state_d;
      pres_state_q  <= pres_state_d;
      pres_action_q <= pres_action_d;
    end
  end

  // Datapath registers, one step per state.
  always_ff @(posedge clk_i) begin
    case (state_q)
      tqdc_pkg::CS_CLASS: begin
        new_state_q <= new_state_d;
        sum_q       <= sum_d;
      end
      tqdc_pkg::CS_RD0:   cost_q   <= cost_d;
      tqdc_pkg::CS_RD1:   row_q[0] <= mem_rd_data_i;
      tqdc_pkg::CS_RD2:   row_q[1] <= mem_rd_data_i;
      tqdc_pkg::CS_RDOLD: row_q[2] <= mem_rd_data_i;
      tqdc_pkg::CS_MIN: begin
        old_q  <= mem_rd_data_i;
        minq_q <= minq_d;
      end
      tqdc_pkg::CS_GMUL:  g_q <= g_d;
      tqdc_pkg::CS_TSUM:  t_q <= t_d;
      tqdc_pkg::CS_UMUL: begin
        p1_q <= p1_d;
        p2_q <= p2_d;
      end
      tqdc_pkg::CS_WRITE: begin
        // Keep the row copy current when the updated entry lies in it.
        if (pres_state_q == new_state_q) begin
          case (pres_action_q)
            tqdc_pkg::ACT_SHORT: row_q[0] <= newq_d;
            tqdc_pkg::ACT_MID:   row_q[1] <= newq_d;
            tqdc_pkg::ACT_LONG:  row_q[2] <= newq_d;
            default:             row_q[0] <= row_q[0];
          endcase
        end
      end
      default: begin
        cost_q <= cost_q;
      end
    endcase
  end

  assign res_o.state_index  = new_state_q;
  assign res_o.action_index = act_d;
  assign res_o.blank_tenths = tqdc_pkg::blank_of(act_d);
  assign res_o.cost_q8      = cost_q;

endmodule

// ===== hdl/tabular_q_learning_duty_controller_core.sv =====
// Top level of the Q-learning duty controller: registers, output stage and unit wiring.
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    lte_bytes_i, wifi_bytes_i
// output    out_valid_o / out_ready_i  state_index_o, action_index_o, blank_tenths_o, cost_q8_o
// config    cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// An item with a nonzero LTE count passes through the two byte-to-throughput
// dividers (4 quotient bits a cycle), the one-port reads of the Q table and the
// update until its result request is loaded into the output register; the next
// item is taken in the cycle after at the earliest, so one item is in work at a time.
// An item with a zero LTE count is taken and gives no result.
// After reset the Q table reads as zero; no clearing pass is needed.
// A result waits in the output register, so the next item is taken while it stalls.

module tabular_q_learning_duty_controller_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tqdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tqdc_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tqdc_pkg::BYTES_W-1:0]        lte_bytes_i,
  input  logic [tqdc_pkg::BYTES_W-1:0]        wifi_bytes_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tqdc_pkg::STATE_W-1:0]        state_index_o,
  output logic [tqdc_pkg::ACT_W-1:0]          action_index_o,
  output logic [tqdc_pkg::BLANK_W-1:0]        blank_tenths_o,
  output logic [tqdc_pkg::COST_W-1:0]         cost_q8_o
);

  tqdc_pkg::cfg_t      cfg_q, cfg_d;
  tqdc_pkg::qmem_req_t mem_req;
  tqdc_pkg::result_t   res, out_res_q;

  logic                           out_valid_q, out_valid_d;
  logic                           out_free;
  logic                           res_valid;
  logic                           div_start;
  logic                           lte_done;
  logic                           wifi_done;
  logic [tqdc_pkg::TPUT_W-1:0]    lte_tput, wifi_tput;
  logic [tqdc_pkg::Q_WIDTH-1:0]   mem_rd_data;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tqdc_pkg::CFG_LEARN_RATE: cfg_d.learn_rate = cfg_wdata_i;
        tqdc_pkg::CFG_DISCOUNT:   cfg_d.discount   = cfg_wdata_i;
        tqdc_pkg::CFG_LOW_THR:    cfg_d.low_thr    = cfg_wdata_i[tqdc_pkg::THR_W-1:0];
        tqdc_pkg::CFG_HIGH_THR:   cfg_d.high_thr   = cfg_wdata_i[tqdc_pkg::THR_W-1:0];
        tqdc_pkg::CFG_TARGET:     cfg_d.target     = cfg_wdata_i[tqdc_pkg::THR_W-1:0];
        default:                  cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_rate <= 17'd32768;
      cfg_q.discount   <= 17'd58982;
      cfg_q.low_thr    <= 10'd10;
      cfg_q.high_thr   <= 10'd30;
      cfg_q.target     <= 10'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Output register between the sequencer and the result channel.
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = res_valid ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_free ? out_valid_d : out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_res_q <= res;
    end
  end

  // Throughput dividers, one per link.
  tqdc_div u_div_lte (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .bytes_i (lte_bytes_i),
    .done_o  (lte_done),
    .quot_o  (lte_tput)
  );

  tqdc_div u_div_wifi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .bytes_i (wifi_bytes_i),
    .done_o  (wifi_done),
    .quot_o  (wifi_tput)
  );

  // Q table memory.
  tqdc_qmem u_qmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  // Sequencer and update datapath.
  tqdc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .lte_bytes_i   (lte_bytes_i),
    .div_start_o   (div_start),
    .div_done_i    (lte_done && wifi_done),
    .lte_tput_i    (lte_tput),
    .wifi_tput_i   (wifi_tput),
    .mem_req_o     (mem_req),
    .mem_rd_data_i (mem_rd_data),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign out_valid_o    = out_valid_q;
  assign state_index_o  = out_res_q.state_index;
  assign action_index_o = out_res_q.action_index;
  assign blank_tenths_o = out_res_q.blank_tenths;
  assign cost_q8_o      = out_res_q.cost_q8;

endmodule

// ===== sim/tabular_q_learning_duty_controller_core_test.sv =====
// Self-checking testbench for the Q-learning duty controller core.
`timescale 1ns / 1ps

module tabular_q_learning_duty_controller_core_test;
  import tqdc_pkg::*;

  localparam int ACTIONS       = 3;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 125;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [BYTES_W-1:0]   lte_bytes_i;
  logic [BYTES_W-1:0]   wifi_bytes_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STATE_W-1:0]   state_index_o;
  logic [ACT_W-1:0]     action_index_o;
  logic [BLANK_W-1:0]   blank_tenths_o;
  logic [COST_W-1:0]    cost_q8_o;

  // Shadow copy of the register file and the learning state.
  logic [CFG_W-1:0]   rate_cfg;
  logic [CFG_W-1:0]   discount_cfg;
  logic [THR_W-1:0]   low_mbps_cfg;
  logic [THR_W-1:0]   high_mbps_cfg;
  logic [THR_W-1:0]   target_mbps_cfg;
  logic [Q_WIDTH-1:0] cost_table [N_ENTRIES];
  logic [STATE_W-1:0] prev_state;
  logic [ACT_W-1:0]   prev_action;

  result_t due_results [$];
  result_t want_result;
  int      error_count;
  bit      sender_gaps_on;
  bit      sink_stalls_on;
  bit      hold_request;

  tabular_q_learning_duty_controller_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .lte_bytes_i    (lte_bytes_i),
    .wifi_bytes_i   (wifi_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .state_index_o  (state_index_o),
    .action_index_o (action_index_o),
    .blank_tenths_o (blank_tenths_o),
    .cost_q8_o      (cost_q8_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor(x * f / 65536), exact.
  function automatic logic [63:0] scale_q16(input logic [63:0] x, input logic [CFG_W-1:0] f);
    logic [80:0] prod;
    prod = x * f;
    return prod[79:16];
  endfunction

  // Throughput in Q8 Mbps from a byte count of one interval.
  function automatic logic [63:0] bytes_to_tput(input logic [BYTES_W-1:0] bytes);
    logic [63:0] num;
    num = {32'd0, bytes} << FRAC_BITS;
    return num / 64'(BYTES_PER_MBPS);
  endfunction

  // Cheapest action of one row; the first one wins a tie.
  function automatic logic [ACT_W-1:0] cheapest_action(input logic [STATE_W-1:0] s);
    int base;
    logic [ACT_W-1:0] best;
    base = int'(s) * ACTIONS;
    best = ACT_SHORT;
    for (int a = 1; a < ACTIONS; a++) begin
      if (cost_table[base + a] < cost_table[base + int'(best)]) best = ACT_W'(a);
    end
    return best;
  endfunction

  // Learn from one request and queue the result it should produce.
  task automatic learn_and_pick(input logic [BYTES_W-1:0] lte_b, input logic [BYTES_W-1:0] wifi_b);
    logic [63:0]        lte, wifi, low, high, target, sum, cost, minq, g, t, qmax;
    logic [CFG_W-1:0]   alpha, gamma;
    logic [STATE_W-1:0] next_state;
    logic [ACT_W-1:0]   act;
    int                 idx;
    result_t            predicted;
    if (lte_b == '0) return;
    lte    = bytes_to_tput(lte_b);
    wifi   = bytes_to_tput(wifi_b);
    low    = 64'(low_mbps_cfg) << FRAC_BITS;
    high   = 64'(high_mbps_cfg) << FRAC_BITS;
    target = 64'(target_mbps_cfg) << FRAC_BITS;
    if (lte <= low) next_state = TS_LOW;
    else if (lte <= high) next_state = TS_MID;
    else next_state = TS_HIGH;
    sum  = lte + wifi;
    cost = (target >= sum) ? target - sum : sum - target;
    if (cost > 64'hFFFF_FFFF) cost = 64'hFFFF_FFFF;
    // Fractions above one act as one.
    alpha = (rate_cfg > CFG_W'(ONE_Q16)) ? CFG_W'(ONE_Q16) : rate_cfg;
    gamma = (discount_cfg > CFG_W'(ONE_Q16)) ? CFG_W'(ONE_Q16) : discount_cfg;
    qmax  = (64'd1 << Q_WIDTH) - 64'd1;
    minq  = 64'(cost_table[int'(next_state) * ACTIONS + int'(cheapest_action(next_state))]);
    g     = scale_q16(minq, gamma);
    t     = (g > qmax - cost) ? qmax : g + cost;
    idx   = int'(prev_state) * ACTIONS + int'(prev_action);
    cost_table[idx] = Q_WIDTH'(scale_q16(64'(cost_table[idx]), CFG_W'(ONE_Q16) - alpha)
                               + scale_q16(t, alpha));
    act = cheapest_action(next_state);
    prev_state  = next_state;
    prev_action = act;
    predicted.state_index  = next_state;
    predicted.action_index = act;
    case (act)
      ACT_MID:  predicted.blank_tenths = BLANK_MID;
      ACT_LONG: predicted.blank_tenths = BLANK_LONG;
      default:  predicted.blank_tenths = BLANK_SHORT;
    endcase
    predicted.cost_q8 = cost[COST_W-1:0];
    due_results.push_back(predicted);
  endtask

  // Observe register writes, input requests and result requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: state %0d action %0d blank %0d cost %0d",
                 state_index_o, action_index_o, blank_tenths_o, cost_q8_o);
          error_count++;
        end else begin
          want_result = due_results.pop_front();
          if (state_index_o !== want_result.state_index) begin
            $error("state_index mismatch: expected %0d, got %0d",
                   want_result.state_index, state_index_o);
            error_count++;
          end
          if (action_index_o !== want_result.action_index) begin
            $error("action_index mismatch: expected %0d, got %0d",
                   want_result.action_index, action_index_o);
            error_count++;
          end
          if (blank_tenths_o !== want_result.blank_tenths) begin
            $error("blank_tenths mismatch: expected %0d, got %0d",
                   want_result.blank_tenths, blank_tenths_o);
            error_count++;
          end
          if (cost_q8_o !== want_result.cost_q8) begin
            $error("cost_q8 mismatch: expected %0d, got %0d", want_result.cost_q8, cost_q8_o);
            error_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LEARN_RATE: rate_cfg        = cfg_wdata_i;
          CFG_DISCOUNT:   discount_cfg    = cfg_wdata_i;
          CFG_LOW_THR:    low_mbps_cfg    = cfg_wdata_i[THR_W-1:0];
          CFG_HIGH_THR:   high_mbps_cfg   = cfg_wdata_i[THR_W-1:0];
          CFG_TARGET:     target_mbps_cfg = cfg_wdata_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) learn_and_pick(lte_bytes_i, wifi_bytes_i);
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    int run_left, stall_left;
    run_left    = 0;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (run_left == 0 && stall_left == 0) begin
        run_left   = $urandom_range(0, 8);
        stall_left = sink_stalls_on ? pick_gap() : 0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  // Offer one input request and wait until it is taken. Valid stays high on return;
  // the next call either replaces the payload or drops valid at the next falling edge.
  task automatic send_request(input logic [BYTES_W-1:0] lte_b, input logic [BYTES_W-1:0] wifi_b);
    int gap;
    gap = sender_gaps_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    lte_bytes_i  <= lte_b;
    wifi_bytes_i <= wifi_b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop offering, wait for every result, then let skipped requests settle.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] disc,
                              input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] high,
                              input logic [CFG_W-1:0] target);
    drain_pipeline();
    write_reg(CFG_LEARN_RATE, rate);
    write_reg(CFG_DISCOUNT, disc);
    write_reg(CFG_LOW_THR, low);
    write_reg(CFG_HIGH_THR, high);
    write_reg(CFG_TARGET, target);
  endtask

  // Threshold edges, zero LTE counts, argmin ties and extreme counts at reset settings.
  task automatic test_reset_defaults();
    send_request(0, 32'hFFFF_FFFF);
    send_request(1, 0);
    send_request(10 * BYTES_PER_MBPS, 0);
    send_request(10 * BYTES_PER_MBPS + 20, 0);
    send_request(30 * BYTES_PER_MBPS, 100 * BYTES_PER_MBPS);
    send_request(30 * BYTES_PER_MBPS + 20, 0);
    send_request(100 * BYTES_PER_MBPS, 100 * BYTES_PER_MBPS);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 0);
    send_request(0, 0);
    send_request(1, 32'hFFFF_FFFF);
  endtask

  // Register extremes: no learning, full learning, fractions above one, inverted
  // thresholds, stray upper bits and writes to unused indexes.
  task automatic test_register_extremes();
    program_regs('0, '0, '0, '0, '0);
    send_request(1, 0);
    send_request(3 * BYTES_PER_MBPS, 7 * BYTES_PER_MBPS);
    send_request(32'h8000_0000, 32'h7FFF_FFFF);
    program_regs(CFG_W'(ONE_Q16), CFG_W'(ONE_Q16), 17'd1023, 17'd1023, 17'd1023);
    send_request(1023 * BYTES_PER_MBPS, 0);
    send_request(1023 * BYTES_PER_MBPS + 20, 1023 * BYTES_PER_MBPS);
    send_request(500 * BYTES_PER_MBPS, 523 * BYTES_PER_MBPS);
    program_regs('1, '1, 17'h1FC00 | 17'd20, 17'h0FC00 | 17'd5, 17'h15400 | 17'd200);
    send_request(20 * BYTES_PER_MBPS, 0);
    send_request(10 * BYTES_PER_MBPS, 0);
    send_request(21 * BYTES_PER_MBPS, 179 * BYTES_PER_MBPS);
    drain_pipeline();
    for (int k = int'(CFG_TARGET) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CFG_W'($urandom));
    send_request(15 * BYTES_PER_MBPS, 0);
    send_request(40 * BYTES_PER_MBPS, 1);
  endtask

  // Hold results back for a long stretch while requests keep coming without gaps.
  task automatic test_output_backpressure();
    program_regs(17'd32768, 17'd58982, 17'd10, 17'd30, 17'd200);
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    hold_request   = 1'b1;
    for (int n = 0; n < 12; n++)
      send_request($urandom_range(1, 50 * BYTES_PER_MBPS), $urandom_range(0, 250 * BYTES_PER_MBPS));
  endtask

  function automatic logic [CFG_W-1:0] pick_fraction();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'(ONE_Q16);
    if (r == 2) return '1;
    if (r == 3) return CFG_W'($urandom_range(ONE_Q16 + 1, (1 << CFG_W) - 1));
    return CFG_W'($urandom_range(1, ONE_Q16 - 1));
  endfunction

  function automatic logic [CFG_W-1:0] pick_threshold_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CFG_W'($urandom);
    if (r < 20) return '0;
    if (r < 30) return CFG_W'((1 << THR_W) - 1);
    return CFG_W'($urandom_range(0, 150));
  endfunction

  // LTE counts: mostly around the thresholds, some across the whole range.
  function automatic logic [BYTES_W-1:0] pick_lte_bytes();
    int unsigned r, thr, base, off, top;
    r   = $urandom_range(0, 99);
    top = (low_mbps_cfg > high_mbps_cfg) ? 32'(low_mbps_cfg) : 32'(high_mbps_cfg);
    if (r < 12) return $urandom;
    if (r < 35) begin
      thr  = r[0] ? 32'(low_mbps_cfg) : 32'(high_mbps_cfg);
      base = thr * BYTES_PER_MBPS;
      off  = $urandom_range(0, 40);
      return (base + off > 20) ? base + off - 20 : 1;
    end
    return $urandom_range(1, (top + 40) * BYTES_PER_MBPS);
  endfunction

  function automatic logic [BYTES_W-1:0] pick_wifi_bytes();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom;
    if (r < 17) return 0;
    return $urandom_range(0, (int'(target_mbps_cfg) + 40) * BYTES_PER_MBPS);
  endfunction

  // Random phases, each with its own settings and idling pattern.
  task automatic test_random_traffic();
    int taken;
    logic [CFG_W-1:0] low_w, high_w;
    logic [BYTES_W-1:0] lte_b;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      low_w  = pick_threshold_word();
      high_w = ($urandom_range(0, 3) != 0) ? CFG_W'(low_w[THR_W-1:0]) + CFG_W'($urandom_range(1, 100))
                                          : pick_threshold_word();
      program_regs(pick_fraction(), pick_fraction(), low_w, high_w,
                   ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(0, 1) * 1023)
                                               : CFG_W'($urandom_range(0, 1023)));
      sender_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      sink_stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 5) begin
          send_request(0, $urandom);
        end else begin
          lte_b = pick_lte_bytes();
          send_request(lte_b, pick_wifi_bytes());
          if (lte_b != '0) taken++;
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    lte_bytes_i     = '0;
    wifi_bytes_i    = '0;
    error_count     = 0;
    sender_gaps_on  = 1'b1;
    sink_stalls_on  = 1'b1;
    hold_request    = 1'b0;
    rate_cfg        = 17'd32768;
    discount_cfg    = 17'd58982;
    low_mbps_cfg    = 10'd10;
    high_mbps_cfg   = 10'd30;
    target_mbps_cfg = 10'd200;
    prev_state      = TS_LOW;
    prev_action     = ACT_SHORT;
    for (int i = 0; i < N_ENTRIES; i++) cost_table[i] = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    drain_pipeline();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
